### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
    localparam int          CMD_DEPTH_DEF  = 4;
    localparam int          CMD_BYTES      = 6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HEX  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NUL      = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef enum logic [5:0] {
        M_TEXT     = 6'b000001,
        M_ESC      = 6'b000010,
        M_HEX      = 6'b000100,
        M_HIGH     = 6'b001000,
        M_HIGH_ESC = 6'b010000,
        M_LOW_HEX  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_t;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [2:0]                nb;
        logic                      done;
        logic [1:0]                st;
        logic [15:0]               base;
    } cmd_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.val   = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end
        else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_enc(input logic [20:0] cp);
        utf8_t u;
        u.b = '0;
        if (cp <= 21'h7F) begin
            u.len  = 3'd1;
            u.b[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            u.len  = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            u.len  = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            u.len  = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

### design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser: one raw byte per cycle unless fifo_full; tracks escape state, byte count;
// turns each byte into at most one command of up to six output bytes plus close.
// ----------------------------------------------------------------------------
module jsu_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    in_byte,
    input  logic          fifo_full,
    input  logic [15:0]   capacity,
    output logic          cmd_wr,
    output jsu_pkg::cmd_t cmd
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    acc_reg, acc_next;
    logic [1:0]     dig_reg, dig_next;
    logic [9:0]     ph_reg, ph_next;
    logic [15:0]    count_reg, count_next;

    logic           accept;
    jsu_pkg::hex_t  hx;
    logic [15:0]    new_acc;
    logic           acc_done;
    logic [20:0]    pair_cp;
    jsu_pkg::utf8_t enc_new, enc_hi, enc_main;
    logic [16:0]    cnt0, cap17;
    logic           flush_fit, flush_ok, room0, fit_new0, fit_new3, fit_pair;
    logic           new_is_high, new_is_low;

    logic           pre, main, main_raw, fin;
    logic [7:0]     main_rawc;
    logic [20:0]    main_cp;
    logic [1:0]     st;
    logic [2:0]     mlen, nb;

    assign accept   = push && !fifo_full;
    assign hx       = jsu_pkg::hex_decode(in_byte);
    assign new_acc  = {acc_reg[11:0], hx.val};
    assign acc_done = (dig_reg == 2'd3);
    assign pair_cp  = jsu_pkg::SUPP_BASE + {1'b0, ph_reg, new_acc[9:0]};
    assign enc_new  = jsu_pkg::utf8_enc({5'd0, new_acc});
    assign enc_hi   = jsu_pkg::utf8_enc({5'd0, jsu_pkg::SURR_HIGH_TAG, ph_reg});
    assign enc_main = jsu_pkg::utf8_enc(main_cp);

    assign cnt0      = {1'b0, count_reg};
    assign cap17     = {1'b0, capacity};
    assign flush_fit = (cnt0 + 17'd3) <= cap17;
    assign flush_ok  = (cnt0 + 17'd3) < cap17;
    assign room0     = cnt0 < cap17;
    assign fit_new0  = (cnt0 + {14'd0, enc_new.len}) <= cap17;
    assign fit_new3  = (cnt0 + 17'd3 + {14'd0, enc_new.len}) <= cap17;
    assign fit_pair  = (cnt0 + 17'd4) <= cap17;

    assign new_is_high = (new_acc[15:10] == jsu_pkg::SURR_HIGH_TAG);
    assign new_is_low  = (new_acc[15:10] == jsu_pkg::SURR_LOW_TAG);

    always_comb
    begin
        pre       = 1'b0;
        main      = 1'b0;
        main_raw  = 1'b0;
        main_rawc = 8'd0;
        main_cp   = {5'd0, new_acc};
        fin       = 1'b0;
        st        = jsu_pkg::ST_OK;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        dig_next  = dig_reg;
        ph_next   = ph_reg;

        unique case (mode_reg)
            jsu_pkg::M_ESC:
            begin
                if (in_byte == jsu_pkg::CH_NUL) begin
                    fin = 1'b1;
                    st  = jsu_pkg::ST_NUL;
                end
                else if (in_byte == jsu_pkg::CH_U) begin
                    mode_next = jsu_pkg::M_HEX;
                    acc_next  = 16'd0;
                    dig_next  = 2'd0;
                end
                else begin
                    mode_next = jsu_pkg::M_TEXT;
                    if (room0) begin
                        main      = 1'b1;
                        main_raw  = 1'b1;
                        main_rawc = jsu_pkg::esc_char(in_byte);
                    end
                    else begin
                        fin = 1'b1;
                        st  = jsu_pkg::ST_OVERFLOW;
                    end
                end
            end
            jsu_pkg::M_HEX:
            begin
                if (!hx.valid) begin
                    fin = 1'b1;
                    st  = jsu_pkg::ST_BAD_HEX;
                end
                else begin
                    acc_next = new_acc;
                    if (!acc_done) begin
                        dig_next = dig_reg + 2'd1;
                    end
                    else if (new_is_high) begin
                        ph_next   = new_acc[9:0];
                        mode_next = jsu_pkg::M_HIGH;
                    end
                    else if (fit_new0) begin
                        main      = 1'b1;
                        mode_next = jsu_pkg::M_TEXT;
                    end
                    else begin
                        fin = 1'b1;
                        st  = jsu_pkg::ST_OVERFLOW;
                    end
                end
            end
            jsu_pkg::M_HIGH:
            begin
                if (in_byte == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::M_HIGH_ESC;
                end
                else if (!flush_ok) begin
                    pre = flush_fit;
                    fin = 1'b1;
                    st  = jsu_pkg::ST_OVERFLOW;
                end
                else begin
                    pre       = 1'b1;
                    mode_next = jsu_pkg::M_TEXT;
                    if (in_byte == jsu_pkg::CH_QUOTE) begin
                        fin = 1'b1;
                        st  = jsu_pkg::ST_OK;
                    end
                    else if (in_byte == jsu_pkg::CH_NUL) begin
                        fin = 1'b1;
                        st  = jsu_pkg::ST_NUL;
                    end
                    else begin
                        main      = 1'b1;
                        main_raw  = 1'b1;
                        main_rawc = in_byte;
                    end
                end
            end
            jsu_pkg::M_HIGH_ESC:
            begin
                if (in_byte == jsu_pkg::CH_U) begin
                    mode_next = jsu_pkg::M_LOW_HEX;
                    acc_next  = 16'd0;
                    dig_next  = 2'd0;
                end
                else if (!flush_ok) begin
                    pre = flush_fit;
                    fin = 1'b1;
                    st  = jsu_pkg::ST_OVERFLOW;
                end
                else begin
                    pre       = 1'b1;
                    mode_next = jsu_pkg::M_TEXT;
                    if (in_byte == jsu_pkg::CH_NUL) begin
                        fin = 1'b1;
                        st  = jsu_pkg::ST_NUL;
                    end
                    else begin
                        main      = 1'b1;
                        main_raw  = 1'b1;
                        main_rawc = jsu_pkg::esc_char(in_byte);
                    end
                end
            end
            jsu_pkg::M_LOW_HEX:
            begin
                if (!hx.valid) begin
                    pre = flush_fit;
                    fin = 1'b1;
                    st  = flush_ok ? jsu_pkg::ST_BAD_HEX : jsu_pkg::ST_OVERFLOW;
                end
                else begin
                    acc_next = new_acc;
                    if (!acc_done) begin
                        dig_next = dig_reg + 2'd1;
                    end
                    else if (new_is_low) begin
                        if (fit_pair) begin
                            main      = 1'b1;
                            main_cp   = pair_cp;
                            mode_next = jsu_pkg::M_TEXT;
                        end
                        else begin
                            fin = 1'b1;
                            st  = jsu_pkg::ST_OVERFLOW;
                        end
                    end
                    else if (!flush_ok) begin
                        pre = flush_fit;
                        fin = 1'b1;
                        st  = jsu_pkg::ST_OVERFLOW;
                    end
                    else begin
                        pre = 1'b1;
                        if (new_is_high) begin
                            ph_next   = new_acc[9:0];
                            mode_next = jsu_pkg::M_HIGH;
                        end
                        else if (fit_new3) begin
                            main      = 1'b1;
                            mode_next = jsu_pkg::M_TEXT;
                        end
                        else begin
                            fin = 1'b1;
                            st  = jsu_pkg::ST_OVERFLOW;
                        end
                    end
                end
            end
            default:
            begin
                mode_next = jsu_pkg::M_TEXT;
                if (in_byte == jsu_pkg::CH_QUOTE) begin
                    fin = 1'b1;
                    st  = jsu_pkg::ST_OK;
                end
                else if (in_byte == jsu_pkg::CH_NUL) begin
                    fin = 1'b1;
                    st  = jsu_pkg::ST_NUL;
                end
                else if (!room0) begin
                    fin = 1'b1;
                    st  = jsu_pkg::ST_OVERFLOW;
                end
                else if (in_byte == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::M_ESC;
                end
                else begin
                    main      = 1'b1;
                    main_raw  = 1'b1;
                    main_rawc = in_byte;
                end
            end
        endcase

        if (fin) begin
            mode_next = jsu_pkg::M_TEXT;
            acc_next  = 16'd0;
            dig_next  = 2'd0;
            ph_next   = 10'd0;
        end
    end

    always_comb
    begin
        mlen = main_raw ? 3'd1 : enc_main.len;
        nb   = (pre ? 3'd3 : 3'd0) + (main ? mlen : 3'd0);

        cmd.bytes = '0;
        if (pre) begin
            for (int i = 0; i < 3; i++) begin
                cmd.bytes[i] = enc_hi.b[i];
            end
        end
        if (main) begin
            if (pre) begin
                for (int k = 0; k < 3; k++) begin
                    if (3'(k) < mlen) begin
                        cmd.bytes[k + 3] = main_raw ? main_rawc : enc_main.b[k];
                    end
                end
            end
            else begin
                for (int k = 0; k < 4; k++) begin
                    if (3'(k) < mlen) begin
                        cmd.bytes[k] = main_raw ? main_rawc : enc_main.b[k];
                    end
                end
            end
        end
        cmd.nb   = nb;
        cmd.done = fin;
        cmd.st   = st;
        cmd.base = count_reg;

        cmd_wr     = accept && (fin || (nb != 3'd0));
        count_next = fin ? 16'd0 : (count_reg + {13'd0, nb});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= jsu_pkg::M_TEXT;
            acc_reg   <= 16'd0;
            dig_reg   <= 2'd0;
            ph_reg    <= 10'd0;
            count_reg <= 16'd0;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
            ph_reg    <= ph_next;
            count_reg <= count_next;
        end
    end

endmodule

### design/jsu_cmd_fifo.sv
// ----------------------------------------------------------------------------
// jsu_cmd_fifo
// Short command queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo
#(
    parameter int DEPTH = jsu_pkg::CMD_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  jsu_pkg::cmd_t wr_data,
    input  logic          rd,
    output jsu_pkg::cmd_t rd_data,
    output logic          full,
    output logic          not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result sequencer: walks one command into the output register, a result per
// cycle unless a result waits unpopped; bytes first, then any closing result.
// ----------------------------------------------------------------------------
module jsu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  jsu_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          done_res,
    output logic [1:0]    status,
    output logic [15:0]   out_length,
    output logic          last
);

    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        bvalid_reg, done_reg, last_reg;
    logic [1:0]  status_reg;
    logic [15:0] len_reg;

    logic        advance, is_byte, end_of_cmd;
    logic [2:0]  total_m1;

    assign advance    = cmd_valid && (!out_valid_reg || pop);
    assign is_byte    = idx_reg < cmd.nb;
    assign total_m1   = cmd.nb + {2'd0, cmd.done} - 3'd1;
    assign end_of_cmd = (idx_reg == total_m1);
    assign cmd_pop    = advance && end_of_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (advance) begin
                idx_reg <= end_of_cmd ? 3'd0 : idx_reg + 3'd1;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            byte_reg   <= is_byte ? cmd.bytes[idx_reg] : 8'd0;
            bvalid_reg <= is_byte;
            done_reg   <= !is_byte;
            status_reg <= is_byte ? jsu_pkg::ST_OK : cmd.st;
            len_reg    <= cmd.base + (is_byte ? {13'd0, idx_reg} + 16'd1 : {13'd0, cmd.nb});
            last_reg   <= end_of_cmd;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign done_res   = done_reg;
    assign status     = status_reg;
    assign out_length = len_reg;
    assign last       = last_reg;

endmodule

### design/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Streaming JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Feed the bytes after the opening quote through push/full; read decoded
// bytes and one closing result per string through empty/pop. The parser
// takes one input byte per cycle while full is low and the sequencer delivers
// one result per cycle unless a result waits unpopped, so plain text flows at
// one byte per cycle; the first result of a byte passes the command queue and
// the output register before it reaches the result ports. A byte that expands
// to n results (up to six for a held surrogate flushed ahead of a new code
// point) occupies the result port for all n of them; the CMD_DEPTH-entry command
// queue between the two halves absorbs such bursts, and full rises only once it
// is filled. Write capacity only between strings.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core
#(
    parameter int CMD_DEPTH = jsu_pkg::CMD_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        capacity_we,
    input  logic [15:0] capacity_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [15:0] out_length,
    output logic        last
);

    logic [15:0]   capacity_reg;
    logic          cmd_wr, cmd_pop, cmd_valid;
    jsu_pkg::cmd_t wr_cmd, rd_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= jsu_pkg::CAPACITY_RESET;
        end
        else if (capacity_we) begin
            capacity_reg <= capacity_wdata;
        end
    end

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_byte   (in_byte),
        .fifo_full (full),
        .capacity  (capacity_reg),
        .cmd_wr    (cmd_wr),
        .cmd       (wr_cmd)
    );

    jsu_cmd_fifo
    #(
        .DEPTH (CMD_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cmd_wr),
        .wr_data   (wr_cmd),
        .rd        (cmd_pop),
        .rd_data   (rd_cmd),
        .full      (full),
        .not_empty (cmd_valid)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (rd_cmd),
        .cmd_pop    (cmd_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .done_res   (done_res),
        .status     (status),
        .out_length (out_length),
        .last       (last)
    );

endmodule

### design/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result stream of the unescaper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  in_byte,
    input logic        capacity_we,
    input logic [15:0] capacity_wdata,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        done_res,
    input logic [1:0]  status,
    input logic [15:0] out_length,
    input logic        last
);

    logic unused_in;
    assign unused_in = ^{push, full, in_byte, capacity_we, capacity_wdata};

    `JSU_ASSERT_IMP(a_close_shape, !empty && done_res, !byte_valid && last && out_byte == 8'h00, "closing result malformed")
    `JSU_ASSERT_IMP(a_byte_shape, !empty && byte_valid, !done_res && status == jsu_pkg::ST_OK && out_length != 16'd0, "byte result malformed")
    `JSU_ASSERT_IMP(a_kind, !empty, byte_valid || done_res, "result is neither byte nor close")
    `JSU_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_length) && $stable(last), "stalled result changed")

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (.*);

### tb/sv/utf8_unescape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_unescape_checker
// Watches both queue ports of the JSON string unescaper, decodes every
// accepted input byte into the UTF-8 bytes and closing results it must cause,
// and compares each popped result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module utf8_unescape_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  in_byte,
    input  logic        capacity_we,
    input  logic [15:0] capacity_wdata,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        done_res,
    input  logic [1:0]  status,
    input  logic [15:0] out_length,
    input  logic        last,
    output int          waiting,
    output int          mismatches
);

    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0]  ch;
        logic        vld;
        logic        done;
        logic [1:0]  st;
        logic [15:0] len;
        logic        lst;
    } out_rec_t;

    out_rec_t    out_q[$];
    mode_t       p_mode;
    logic [15:0] p_acc;
    logic [1:0]  p_digits;
    logic [9:0]  p_high;
    logic [15:0] p_count;
    logic [15:0] p_cap;

    function automatic void add_rec(input logic [7:0] ch, input logic vld,
                                    input logic done, input logic [1:0] st);
        out_rec_t r;
        r.ch   = ch;
        r.vld  = vld;
        r.done = done;
        r.st   = st;
        r.len  = p_count;
        r.lst  = 1'b0;
        out_q.push_back(r);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        p_count = p_count + 16'd1;
        add_rec(b, 1'b1, 1'b0, ST_OK);
    endfunction

    function automatic void close_string(input logic [1:0] st);
        add_rec(8'h00, 1'b0, 1'b1, st);
        p_mode   = M_TEXT;
        p_acc    = '0;
        p_digits = '0;
        p_high   = '0;
        p_count  = '0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b - 8'h61) + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b - 8'h41) + 10;
        return -1;
    endfunction

    // Drop the whole sequence when it does not fit.
    function automatic bit emit_code(input logic [20:0] cp);
        int n;
        n = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
        if (int'(p_count) + n > int'(p_cap))
            return 1'b0;
        case (n)
            1:
            begin
                put_byte(cp[7:0]);
            end
            2:
            begin
                put_byte(8'hC0 | cp[10:6]);
                put_byte(8'h80 | cp[5:0]);
            end
            3:
            begin
                put_byte(8'hE0 | cp[15:12]);
                put_byte(8'h80 | cp[11:6]);
                put_byte(8'h80 | cp[5:0]);
            end
            default:
            begin
                put_byte(8'hF0 | cp[20:18]);
                put_byte(8'h80 | cp[17:12]);
                put_byte(8'h80 | cp[11:6]);
                put_byte(8'h80 | cp[5:0]);
            end
        endcase
        return 1'b1;
    endfunction

    function automatic bit flush_high();
        if (!emit_code(21'hD800 + p_high) || p_count >= p_cap)
        begin
            close_string(ST_OVERFLOW);
            return 1'b0;
        end
        p_mode = M_TEXT;
        return 1'b1;
    endfunction

    function automatic void take_code(input logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF)
        begin
            p_high = cp[9:0];
            p_mode = M_HIGH;
        end
        else if (!emit_code({5'd0, cp}))
        begin
            close_string(ST_OVERFLOW);
        end
        else
        begin
            p_mode = M_TEXT;
        end
    endfunction

    function automatic void text_in(input logic [7:0] b);
        if (b == CH_QUOTE)
            close_string(ST_OK);
        else if (b == CH_NUL)
            close_string(ST_NUL);
        else if (p_count >= p_cap)
            close_string(ST_OVERFLOW);
        else if (b == CH_BSLASH)
            p_mode = M_ESC;
        else
            put_byte(b);
    endfunction

    function automatic void esc_in(input logic [7:0] b);
        logic [7:0] c;
        if (b == CH_NUL)
        begin
            close_string(ST_NUL);
            return;
        end
        if (b == CH_U)
        begin
            p_mode   = M_HEX;
            p_acc    = '0;
            p_digits = '0;
            return;
        end
        case (b)
            CH_B:    c = 8'h08;
            CH_F:    c = 8'h0C;
            CH_N:    c = 8'h0A;
            CH_R:    c = 8'h0D;
            CH_T:    c = 8'h09;
            default: c = b;
        endcase
        p_mode = M_TEXT;
        if (p_count >= p_cap)
            close_string(ST_OVERFLOW);
        else
            put_byte(c);
    endfunction

    // 1 when four digits are in, 0 when more are due, -1 on a bad digit
    function automatic int hex_in(input logic [7:0] b);
        int v;
        v = hex_nibble(b);
        if (v < 0)
            return -1;
        p_acc = {p_acc[11:0], v[3:0]};
        if (p_digits == 2'd3)
            return 1;
        p_digits = p_digits + 2'd1;
        return 0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int          h;
        logic [15:0] lo;
        case (p_mode)
            M_ESC:
            begin
                esc_in(b);
            end
            M_HEX:
            begin
                h = hex_in(b);
                if (h < 0)
                    close_string(ST_BAD_HEX);
                else if (h > 0)
                    take_code(p_acc);
            end
            M_HIGH:
            begin
                if (b == CH_BSLASH)
                    p_mode = M_HIGH_ESC;
                else if (flush_high())
                    text_in(b);
            end
            M_HIGH_ESC:
            begin
                if (b == CH_U)
                begin
                    p_mode   = M_LOW_HEX;
                    p_acc    = '0;
                    p_digits = '0;
                end
                else if (flush_high())
                begin
                    esc_in(b);
                end
            end
            M_LOW_HEX:
            begin
                h = hex_in(b);
                if (h < 0)
                begin
                    if (flush_high())
                        close_string(ST_BAD_HEX);
                end
                else if (h > 0)
                begin
                    lo = p_acc;
                    if (lo >= 16'hDC00 && lo <= 16'hDFFF)
                    begin
                        if (!emit_code(21'h10000 + {p_high, lo[9:0]}))
                            close_string(ST_OVERFLOW);
                        else
                            p_mode = M_TEXT;
                    end
                    else if (flush_high())
                    begin
                        take_code(lo);
                    end
                end
            end
            default:
            begin
                text_in(b);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        out_rec_t want;
        out_rec_t tail;
        int       base;
        if (!rst_n)
        begin
            out_q.delete();
            p_mode     = M_TEXT;
            p_acc      = '0;
            p_digits   = '0;
            p_high     = '0;
            p_count    = '0;
            p_cap      = CAPACITY_RESET;
            mismatches = 0;
            waiting   <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (out_q.size() == 0)
                begin
                    $error("result with nothing expected: out_byte 0x%0h done_res %0b",
                           out_byte, done_res);
                    mismatches++;
                end
                else
                begin
                    want = out_q.pop_front();
                    check_field("out_byte", want.ch, out_byte);
                    check_field("byte_valid", want.vld, byte_valid);
                    check_field("done_res", want.done, done_res);
                    check_field("status", want.st, status);
                    check_field("out_length", want.len, out_length);
                    check_field("last", want.lst, last);
                end
            end
            if (capacity_we)
                p_cap = capacity_wdata;
            if (push && !full)
            begin
                base = out_q.size();
                decode_byte(in_byte);
                // flag the final result of this request
                if (out_q.size() > base)
                begin
                    tail     = out_q.pop_back();
                    tail.lst = 1'b1;
                    out_q.push_back(tail);
                end
            end
            waiting <= out_q.size();
        end
    end

endmodule

### tb/sv/json_string_unescape_utf8_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Feeds JSON string bodies to the unescaper: a directed opening, then phases
// of random strings, escapes, surrogate pairs, broken escapes and noise under
// several capacity settings, with random stalls on both queue ports. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_tb;

    import jsu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        capacity_we;
    logic [15:0] capacity_wdata;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] out_length;
    logic        last;
    int          waiting;
    int          mismatches;

    bit          rush;
    int          pop_hold;
    int          sent;
    logic [7:0]  str_q[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    json_string_unescape_utf8_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .done_res       (done_res),
        .status         (status),
        .out_length     (out_length),
        .last           (last)
    );

    utf8_unescape_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_byte        (in_byte),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .done_res       (done_res),
        .status         (status),
        .out_length     (out_length),
        .last           (last),
        .waiting        (waiting),
        .mismatches     (mismatches)
    );

    initial
    begin
        #5_000_000;
        $display("json_string_unescape_utf8_core_tb failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // result side: pop mostly high, with random stalls
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop_hold > 0)
            begin
                pop <= 1'b0;
                pop_hold--;
            end
            else
            begin
                pop <= 1'b1;
                if (!rush && $urandom_range(0, 99) < 25)
                    pop_hold = idle_len();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        push    <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (full);
        sent++;
        gap = (!rush && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_queue();
        foreach (str_q[i])
            send_byte(str_q[i]);
        str_q.delete();
    endtask

    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] v);
        drain();
        capacity_we    <= 1'b1;
        capacity_wdata <= v;
        @(posedge clk);
        capacity_we    <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    function automatic void add_uesc(input logic [15:0] v);
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--)
            str_q.push_back(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic logic [7:0] bad_digit();
        case ($urandom_range(0, 8))
            0:       return CH_NUL;
            1:       return CH_QUOTE;
            2:       return 8'h67;
            3:       return 8'h47;
            4:       return 8'h3A;
            5:       return 8'h2F;
            6:       return 8'h40;
            7:       return 8'h60;
            default: return $urandom_range(128, 255);
        endcase
    endfunction

    function automatic void add_bad_hex();
        int n;
        n = $urandom_range(0, 3);
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        for (int i = 0; i < n; i++)
            str_q.push_back(hex_char($urandom_range(0, 15)));
        str_q.push_back(bad_digit());
    endfunction

    function automatic logic [15:0] high_code();
        return $urandom_range(16'hD800, 16'hDBFF);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = $urandom_range(1, 255);
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic void add_token();
        int          r;
        logic [7:0]  b;
        logic [15:0] cp;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            str_q.push_back(plain_byte());
        end
        else if (r < 48)
        begin
            case ($urandom_range(0, 7))
                0:       b = CH_QUOTE;
                1:       b = CH_BSLASH;
                2:       b = 8'h2F;
                3:       b = CH_B;
                4:       b = CH_F;
                5:       b = CH_N;
                6:       b = CH_R;
                default: b = CH_T;
            endcase
            str_q.push_back(CH_BSLASH);
            str_q.push_back(b);
        end
        else if (r < 53)
        begin
            do
                b = $urandom_range(1, 255);
            while (b == CH_U);
            str_q.push_back(CH_BSLASH);
            str_q.push_back(b);
        end
        else if (r < 68)
        begin
            case ($urandom_range(0, 5))
                0: cp = $urandom_range(0, 16'h7F);
                1: cp = $urandom_range(16'h80, 16'h7FF);
                2: cp = $urandom_range(16'h800, 16'hD7FF);
                3: cp = $urandom_range(16'hE000, 16'hFFFF);
                4: cp = $urandom_range(16'hDC00, 16'hDFFF);
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       cp = 16'h0000;
                        1:       cp = 16'h007F;
                        2:       cp = 16'h0080;
                        3:       cp = 16'h07FF;
                        4:       cp = 16'h0800;
                        default: cp = 16'hFFFF;
                    endcase
                end
            endcase
            add_uesc(cp);
        end
        else if (r < 82)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_uesc($urandom_range(0, 1) ? 16'hD800 : 16'hDBFF);
                add_uesc($urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF);
            end
            else
            begin
                add_uesc(high_code());
                add_uesc($urandom_range(16'hDC00, 16'hDFFF));
            end
        end
        else if (r < 94)
        begin
            add_uesc(high_code());
            case ($urandom_range(0, 3))
                0:
                begin
                    do
                        b = $urandom_range(1, 255);
                    while (b == CH_BSLASH);
                    str_q.push_back(b);
                end
                1:
                begin
                    do
                        b = $urandom_range(1, 255);
                    while (b == CH_U);
                    str_q.push_back(CH_BSLASH);
                    str_q.push_back(b);
                end
                2:
                begin
                    do
                        cp = $urandom_range(0, 16'hFFFF);
                    while (cp >= 16'hDC00 && cp <= 16'hDFFF);
                    add_uesc(cp);
                end
                default:
                begin
                    add_uesc(high_code());
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    add_bad_hex();
                end
                1:
                begin
                    add_uesc(high_code());
                    add_bad_hex();
                end
                default:
                begin
                    add_uesc(high_code());
                    str_q.push_back(CH_BSLASH);
                    str_q.push_back(CH_NUL);
                end
            endcase
        end
    endfunction

    function automatic void add_string();
        int n;
        int r;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
            add_token();
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            str_q.push_back(CH_QUOTE);
        end
        else if (r < 80)
        begin
            str_q.push_back(CH_NUL);
        end
        else if (r < 88)
        begin
            str_q.push_back(CH_BSLASH);
            str_q.push_back(CH_NUL);
        end
        else
        begin
            add_bad_hex();
        end
    endfunction

    initial
    begin : stimulus
        int          phase_start;
        logic [15:0] cap;
        rst_n          = 1'b0;
        push           = 1'b0;
        in_byte        = 8'h00;
        capacity_we    = 1'b0;
        capacity_wdata = 16'h0000;
        rush           = 1'b0;
        pop_hold       = 0;
        sent           = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text extremes, a short escape, the top surrogate pair, then an
        // empty string ended by NUL, NUL after backslash and a bad hex digit
        str_q = '{8'h01, 8'hFF, CH_BSLASH, CH_T,
                  CH_BSLASH, CH_U, 8'h44, 8'h42, 8'h46, 8'h46,
                  CH_BSLASH, CH_U, 8'h64, 8'h66, 8'h66, 8'h66, CH_QUOTE,
                  CH_NUL, CH_BSLASH, CH_NUL, CH_BSLASH, CH_U, 8'h30, 8'h47};
        send_queue();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1:       cap = 16'd1;
                2:       cap = 16'd2;
                3:       cap = 16'd3;
                4:       cap = $urandom_range(4, 8);
                5:       cap = $urandom_range(9, 40);
                6:       cap = $urandom_range(1, 65535);
                default: cap = 16'hFFFF;
            endcase
            if (p > 0)
                set_capacity(cap);
            phase_start = sent;
            while (sent - phase_start < 40)
            begin
                rush = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        str_q.push_back($urandom_range(0, 255));
                end
                else
                begin
                    add_string();
                end
                send_queue();
            end
            rush = 1'b0;
            // close whatever string is open
            send_byte(CH_NUL);
        end

        drain();
        if (mismatches == 0)
            $display("json_string_unescape_utf8_core_tb passed");
        else
            $display("json_string_unescape_utf8_core_tb failed");
        $finish;
    end

endmodule
